/* rtl/core/rsh3_pkg.sv */
// Shared types and constants for the RGB 3x3 sharpen core.
package rsh3_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned GAIN_W     = 9;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH     = 2'd2;

  localparam int unsigned DEF_MAX_WIDTH    = 2048;
  localparam int unsigned DEF_MAX_HEIGHT   = 2048;
  localparam int unsigned FRAME_WIDTH_RST  = 640;
  localparam int unsigned FRAME_HEIGHT_RST = 480;
  localparam int unsigned MIN_DIM          = 2;

  localparam logic [GAIN_W-1:0] GAIN_MAX = 9'd256;

  // arithmetic widths: window sum, 9p - sum, 2304p + g*(9p - sum)
  localparam int unsigned SUM_W = 12;
  localparam int unsigned D_W   = 13;
  localparam int unsigned NUM_W = 22;

  // floor(num / 2304) = floor((num >> 8) / 9); 2304 after the shift saturates
  localparam int unsigned SCALE_SHIFT = 8;
  localparam logic [12:0] Q_SAT       = 13'd2304;
  localparam logic [11:0] DIV9_MUL    = 12'd3641;
  localparam int unsigned DIV9_SHIFT  = 15;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
  } rgb_t;

  // line store entry: the two rows above the incoming one
  typedef struct packed {
    rgb_t prev1;
    rgb_t prev2;
  } line_pair_t;

  // one column of the window, top to bottom
  typedef struct packed {
    rgb_t top;
    rgb_t mid;
    rgb_t bot;
  } col_vec_t;

  typedef struct packed {
    logic row_end;
    logic left_clamp;
    logic top_clamp;
    logic bot_rep;
    logic emit;
    logic eof;
    logic wr;
  } step_t;

  typedef struct packed {
    logic step_go;
    logic ld2;
    logic ld3;
    logic ld4;
  } pipe_t;

  typedef struct packed {
    logic [PIX_W-1:0] p;
    logic [D_W-1:0]   d;
  } tap_t;

endpackage

/* rtl/core/rsh3_if.sv */
// Valid/ready channel interfaces for pixel items in and result items out.
interface rsh3_pix_if;
  import rsh3_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;
  logic             flush;

  modport source (output valid, red_in, green_in, blue_in, flush, input ready);
  modport sink (input valid, red_in, green_in, blue_in, flush, output ready);
endinterface

interface rsh3_res_if;
  import rsh3_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] blue_out;
  logic             end_of_frame;

  modport source (output valid, red_out, green_out, blue_out, end_of_frame, input ready);
  modport sink (input valid, red_out, green_out, blue_out, end_of_frame, output ready);
endinterface

/* rtl/core/rgb_sharpen_3x3_core.sv */
// Top level of the streaming RGB 3x3 high-boost sharpen core.
// Pixels enter in raster order and each channel leaves as
// clamp(floor((2304p + strength*(9p - S)) / 2304), 0, 255), S being the 3x3
// window sum with edge pixels replicated at the frame border. The result for
// pixel m goes out with the input item for pixel m + W + 1, so the first W + 1
// pixels of a frame give no result; after the last pixel, W + 1 flush items
// (or pixel items, whose data is then dropped) drain the tail, the last one
// flagged end_of_frame. A flush with no finished frame pending is taken and
// ignored. One item is accepted per clock while res_o.ready allows; a result
// passes four registers (input register with line store read, window sum,
// boost multiply, divide and clamp) after the item completing its window is
// taken. The line store keeps two rows in one memory of MAX_WIDTH entries,
// read once per item and written back when the item leaves the input
// register; it needs no clearing after reset. Width and height writes
// restart the frame; strength applies to every later result.
// Configuration must be written only while the core is idle; not enforced.
module rgb_sharpen_3x3_core #(
  parameter int unsigned MAX_WIDTH  = rsh3_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = rsh3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rsh3_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rsh3_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rsh3_pix_if.sink                        pix_i,
  rsh3_res_if.source                      res_o
);
  import rsh3_pkg::*;

  // column counter also holds W during the drain
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned W_RST =
    (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
  localparam int unsigned H_RST =
    (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

  // ---------------------------------------------------------------- config
  logic [CW-1:0]     w_q, w_new;
  logic [RW-1:0]     h_q, h_new;
  logic [GAIN_W-1:0] gain_q, gain_new;
  logic              geo_wr;

  always_comb begin
    int unsigned val;
    val = 32'(cfg_data_i);
    if (val < MIN_DIM) begin
      w_new = CW'(MIN_DIM);
    end else if (val > MAX_WIDTH) begin
      w_new = CW'(MAX_WIDTH);
    end else begin
      w_new = CW'(val);
    end
    if (val < MIN_DIM) begin
      h_new = RW'(MIN_DIM);
    end else if (val > MAX_HEIGHT) begin
      h_new = RW'(MAX_HEIGHT);
    end else begin
      h_new = RW'(val);
    end
    gain_new = (cfg_data_i[GAIN_W-1:0] > GAIN_MAX) ? GAIN_MAX : cfg_data_i[GAIN_W-1:0];
  end

  assign geo_wr = cfg_we_i &&
                  ((cfg_idx_i == REG_FRAME_WIDTH) || (cfg_idx_i == REG_FRAME_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= CW'(W_RST);
      h_q    <= RW'(H_RST);
      gain_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:  w_q <= w_new;
        REG_FRAME_HEIGHT: h_q <= h_new;
        REG_STRENGTH:     gain_q <= gain_new;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------ pipeline control
  logic  v1_q, v2_q, v3_q, v4_q;
  logic  rdy1, rdy2, rdy3, rdy4;
  step_t step1_q, step_d;
  rgb_t  px1_q;
  logic [AW-1:0] addr1_q;
  logic  eof2_q, eof3_q, eof4_q;
  pipe_t pipe;
  logic  accept, is_step;
  logic  tail_q, tail_d;

  assign rdy4 = !v4_q || res_o.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;

  // steps that give no result leave stage 1 without waiting on stage 2
  assign pipe.step_go = v1_q && (rdy2 || !step1_q.emit);
  assign pipe.ld2     = pipe.step_go && step1_q.emit;
  assign pipe.ld3     = rdy3 && v2_q;
  assign pipe.ld4     = rdy4 && v3_q;
  assign rdy1         = !v1_q || pipe.step_go;

  assign pix_i.ready = rdy1;
  assign accept      = pix_i.valid && rdy1;
  // while a tail is pending every item is a drain step
  assign is_step     = accept && (tail_q || !pix_i.flush);

  // ------------------------------------------------------- frame position
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    tail_d = tail_q;
    if (geo_wr) begin
      col_d  = '0;
      row_d  = '0;
      tail_d = 1'b0;
    end else if (is_step) begin
      if (tail_q) begin
        if (col_q == w_q) begin
          col_d  = '0;
          tail_d = 1'b0;
        end else begin
          col_d = col_q + CW'(1);
        end
      end else if (col_q == w_q - CW'(1)) begin
        col_d = '0;
        if (row_q == h_q - RW'(1)) begin
          row_d  = '0;
          tail_d = 1'b1;
        end else begin
          row_d = row_q + RW'(1);
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  // Window placement: a step at column x centers on column x-1 of the row
  // above; at column 0 (and the final drain step) it closes the previous row.
  always_comb begin
    step_d.row_end    = (col_q == '0) || (tail_q && (col_q == w_q));
    step_d.left_clamp = (col_q == CW'(1));
    step_d.top_clamp  = !tail_q && (row_q == RW'(1));
    step_d.bot_rep    = tail_q;
    step_d.emit       = tail_q || (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));
    step_d.eof        = tail_q && (col_q == w_q);
    step_d.wr         = !tail_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      tail_q <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      tail_q <= tail_d;
      if (rdy1) begin
        v1_q <= is_step;
      end
      if (rdy2) begin
        v2_q <= pipe.ld2;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_step) begin
      step1_q <= step_d;
      px1_q   <= '{r: pix_i.red_in, g: pix_i.green_in, b: pix_i.blue_in};
      addr1_q <= col_q[AW-1:0];
    end
    if (pipe.ld2) begin
      eof2_q <= step1_q.eof;
    end
    if (pipe.ld3) begin
      eof3_q <= eof2_q;
    end
    if (pipe.ld4) begin
      eof4_q <= eof3_q;
    end
  end

  // ------------------------------------------------------------ datapath
  line_pair_t rd_data, wr_data;
  tap_t [2:0] taps;
  logic [2:0][PIX_W-1:0] chan_pix;

  // rows shift down by one on write-back: new pixel over the row above
  assign wr_data = '{prev1: px1_q, prev2: rd_data.prev1};

  rsh3_line_store #(
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (is_step),
    .rd_addr_i (col_q[AW-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (pipe.step_go && step1_q.wr),
    .wr_addr_i (addr1_q),
    .wr_data_i (wr_data)
  );

  rsh3_window u_window (
    .clk_i  (clk_i),
    .pipe_i (pipe),
    .step_i (step1_q),
    .px_i   (px1_q),
    .rd_i   (rd_data),
    .tap_o  (taps)
  );

  // channel 2 is red, 0 is blue
  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    rsh3_chan u_chan (
      .clk_i  (clk_i),
      .pipe_i (pipe),
      .gain_i (gain_q),
      .tap_i  (taps[ch]),
      .pix_o  (chan_pix[ch])
    );
  end

  assign res_o.valid        = v4_q;
  assign res_o.red_out      = chan_pix[2];
  assign res_o.green_out    = chan_pix[1];
  assign res_o.blue_out     = chan_pix[0];
  assign res_o.end_of_frame = eof4_q;

  // ----------------------------------------------------------- assertions
  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tail_q |-> (col_q < w_q) && (row_q < h_q))
    else $error("input position outside the frame");

  a_drain_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q |-> (col_q <= w_q))
    else $error("drain ran past W + 1 steps");

  a_clamp_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> !(step1_q.row_end && step1_q.left_clamp))
    else $error("row end and left clamp on the same step");

  a_eof_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && step1_q.eof) |-> (step1_q.emit && step1_q.bot_rep && !step1_q.wr))
    else $error("end of frame outside the drain");

  a_eof_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && step1_q.eof && pipe.step_go) |=> v2_q && eof2_q)
    else $error("end of frame lost between stages");

endmodule

/* rtl/core/rsh3_line_store.sv */
// Two-row line store: one entry per column, registered read, one write port.
module rsh3_line_store #(
  parameter int unsigned DEPTH = rsh3_pkg::DEF_MAX_WIDTH,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output rsh3_pkg::line_pair_t rd_data_o,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  rsh3_pkg::line_pair_t wr_data_i
);
  import rsh3_pkg::*;

  line_pair_t store_q [DEPTH];
  line_pair_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      store_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= store_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

/* rtl/core/rsh3_window.sv */
// 3x3 window: column registers, edge replication, window sum and 9p - sum.
module rsh3_window (
  input  logic                 clk_i,
  input  rsh3_pkg::pipe_t      pipe_i,
  input  rsh3_pkg::step_t      step_i,
  input  rsh3_pkg::rgb_t       px_i,
  input  rsh3_pkg::line_pair_t rd_i,
  output rsh3_pkg::tap_t [2:0] tap_o
);
  import rsh3_pkg::*;

  col_vec_t col1_q, col2_q;
  col_vec_t vec;
  col_vec_t win_l, win_c, win_r;
  logic [8:0][2:0][PIX_W-1:0] cells;
  tap_t [2:0] tap_d, tap_q;

  always_comb begin
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] ninep;
    // new column: rows y-2, y-1, y with top/bottom replication at frame edges
    vec.mid = rd_i.prev1;
    vec.top = step_i.top_clamp ? rd_i.prev1 : rd_i.prev2;
    vec.bot = step_i.bot_rep ? rd_i.prev1 : px_i;

    win_c = col1_q;
    win_l = step_i.left_clamp ? col1_q : col2_q;
    win_r = step_i.row_end ? col1_q : vec;

    cells[0] = win_l.top;
    cells[1] = win_c.top;
    cells[2] = win_r.top;
    cells[3] = win_l.mid;
    cells[4] = win_c.mid;
    cells[5] = win_r.mid;
    cells[6] = win_l.bot;
    cells[7] = win_c.bot;
    cells[8] = win_r.bot;

    for (int ch = 0; ch < 3; ch++) begin
      sum = '0;
      for (int k = 0; k < 9; k++) begin
        sum = sum + SUM_W'(cells[k][ch]);
      end
      ninep = {1'b0, cells[4][ch], 3'b000} + SUM_W'(cells[4][ch]);
      tap_d[ch].p = cells[4][ch];
      tap_d[ch].d = D_W'(ninep) - D_W'(sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.step_go) begin
      col2_q <= col1_q;
      col1_q <= vec;
    end
    if (pipe_i.ld2) begin
      tap_q <= tap_d;
    end
  end

  assign tap_o = tap_q;

endmodule

/* rtl/core/rsh3_chan.sv */
// Per-channel boost, floor divide by 2304 and clamp to 0..255.
module rsh3_chan (
  input  logic                        clk_i,
  input  rsh3_pkg::pipe_t             pipe_i,
  input  logic [rsh3_pkg::GAIN_W-1:0] gain_i,
  input  rsh3_pkg::tap_t              tap_i,
  output logic [rsh3_pkg::PIX_W-1:0]  pix_o
);
  import rsh3_pkg::*;

  logic signed [NUM_W-1:0] num_d, num_q;
  logic [PIX_W-1:0]        pix_d, pix_q;

  // num = 2304p + g*(9p - sum)
  always_comb begin
    logic signed [NUM_W:0]   prod;
    logic signed [NUM_W-1:0] base;
    prod  = $signed({1'b0, gain_i}) * $signed(tap_i.d);
    base  = $signed({3'b000, tap_i.p, 11'b0}) + $signed({6'b0, tap_i.p, 8'b0});
    num_d = base + prod[NUM_W-1:0];
  end

  always_comb begin
    logic [12:0] q;
    logic [23:0] recip;
    q     = num_q[NUM_W-2:SCALE_SHIFT];
    recip = q[11:0] * DIV9_MUL;
    if (num_q[NUM_W-1]) begin
      pix_d = '0;
    end else if (q >= Q_SAT) begin
      pix_d = PIX_MAX;
    end else begin
      pix_d = recip[DIV9_SHIFT+PIX_W-1:DIV9_SHIFT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.ld3) begin
      num_q <= num_d;
    end
    if (pipe_i.ld4) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

/* tb/rgb_sharpen_3x3_core_tb.sv */
// Self-checking testbench for the streaming RGB 3x3 high-boost sharpen core.
module rgb_sharpen_3x3_core_tb;
  import rsh3_pkg::*;

  // register index with no register behind it, written to check it is ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int unsigned ROW_SLOTS      = 3;
  localparam int          BOOST_SCALE    = 9 * 256;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS   = 1000;
  localparam int unsigned REPORT_MAX     = 10;

  // how a directed row is handled
  typedef enum logic [1:0] {
    ROW_CFG,    // register write
    ROW_NONE,   // item, no result expected
    ROW_GIVEN,  // item, result typed in the table
    ROW_PRED    // item, result from the predictor
  } row_kind_e;

  typedef struct packed {
    rgb_t px;
    logic eof;
  } sharp_res_t;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    rgb_t                  px;
    logic                  fl;
    rgb_t                  exp_px;
    logic                  exp_eof;
  } dir_row_t;

  localparam int DIR_ROWS = 26;

  // Directed part. A 2x2 frame at zero gain comes out unchanged, so its results
  // are typed in; the rest goes through the predictor.
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{ROW_NONE,  '0, '0, 24'h000000, 1'b1, '0, 1'b0},       // flush right after reset
    '{ROW_CFG,   REG_FRAME_WIDTH,  12'd0,   '0, 1'b0, '0, 1'b0},  // clamps to 2
    '{ROW_CFG,   REG_FRAME_HEIGHT, 12'd1,   '0, 1'b0, '0, 1'b0},  // clamps to 2
    '{ROW_CFG,   REG_STRENGTH,     12'd0,   '0, 1'b0, '0, 1'b0},
    '{ROW_CFG,   REG_UNUSED,       12'hFFF, '0, 1'b0, '0, 1'b0},
    '{ROW_NONE,  '0, '0, 24'h000000, 1'b0, '0, 1'b0},       // warm-up
    '{ROW_NONE,  '0, '0, 24'hFFFFFF, 1'b0, '0, 1'b0},
    '{ROW_NONE,  '0, '0, 24'h00FF00, 1'b0, '0, 1'b0},
    '{ROW_GIVEN, '0, '0, 24'hFF00FF, 1'b0, 24'h000000, 1'b0},
    '{ROW_GIVEN, '0, '0, 24'h000000, 1'b1, 24'hFFFFFF, 1'b0},
    '{ROW_GIVEN, '0, '0, 24'h123456, 1'b0, 24'h00FF00, 1'b0},  // pixel dropped in drain
    '{ROW_GIVEN, '0, '0, 24'h000000, 1'b1, 24'hFF00FF, 1'b1},
    '{ROW_NONE,  '0, '0, 24'h000000, 1'b1, '0, 1'b0},       // nothing left to drain
    '{ROW_CFG,   REG_STRENGTH,     12'h1FF, '0, 1'b0, '0, 1'b0},  // saturates to 256
    '{ROW_PRED,  '0, '0, 24'hFF0080, 1'b0, '0, 1'b0},
    '{ROW_PRED,  '0, '0, 24'h00FF07, 1'b0, '0, 1'b0},
    '{ROW_PRED,  '0, '0, 24'h00FFC8, 1'b0, '0, 1'b0},
    '{ROW_PRED,  '0, '0, 24'hFF0001, 1'b0, '0, 1'b0},
    '{ROW_PRED,  '0, '0, 24'h000000, 1'b1, '0, 1'b0},
    '{ROW_PRED,  '0, '0, 24'h000000, 1'b1, '0, 1'b0},
    '{ROW_PRED,  '0, '0, 24'h000000, 1'b1, '0, 1'b0},
    '{ROW_CFG,   REG_FRAME_WIDTH,  12'd3,   '0, 1'b0, '0, 1'b0},
    '{ROW_PRED,  '0, '0, 24'h808080, 1'b0, '0, 1'b0},
    '{ROW_PRED,  '0, '0, 24'h7F7F7F, 1'b0, '0, 1'b0},
    '{ROW_PRED,  '0, '0, 24'h000000, 1'b1, '0, 1'b0},       // flush mid-frame
    '{ROW_CFG,   REG_FRAME_HEIGHT, 12'd3,   '0, 1'b0, '0, 1'b0}   // abandons the frame
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  rsh3_pix_if pix_if ();
  rsh3_res_if res_if ();

  rgb_sharpen_3x3_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_if),
    .res_o      (res_if)
  );

  // ---------------------------------------------------------------------------
  // Sharpen predictor: own copy of registers, line rows and positions
  // ---------------------------------------------------------------------------
  logic [11:0]       width_reg;
  logic [11:0]       height_reg;
  logic [GAIN_W-1:0] gain_reg;
  rgb_t              row_store [ROW_SLOTS*DEF_MAX_WIDTH];
  logic [23:0]       win_taps [9];
  int unsigned       col_pos;
  int unsigned       row_pos;
  int unsigned       out_idx;
  bit                tail_due;

  sharp_res_t  due_pixels [$];   // sharpened pixels still to come out
  int unsigned fail_count;
  bit          send_calm;
  bit          recv_calm;
  int unsigned idle_cycles;

  function automatic int unsigned frame_w();
    int unsigned v;
    v = width_reg;
    if (v < MIN_DIM) v = MIN_DIM;
    if (v > DEF_MAX_WIDTH) v = DEF_MAX_WIDTH;
    return v;
  endfunction

  function automatic int unsigned frame_h();
    int unsigned v;
    v = height_reg;
    if (v < MIN_DIM) v = MIN_DIM;
    if (v > DEF_MAX_HEIGHT) v = DEF_MAX_HEIGHT;
    return v;
  endfunction

  function automatic void sharpen_reset();
    width_reg  = FRAME_WIDTH_RST;
    height_reg = FRAME_HEIGHT_RST;
    gain_reg   = '0;
    col_pos    = 0;
    row_pos    = 0;
    out_idx    = 0;
    tail_due   = 1'b0;
  endfunction

  function automatic void sharpen_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_FRAME_WIDTH, REG_FRAME_HEIGHT: begin
        if (idx == REG_FRAME_WIDTH) width_reg = data;
        else height_reg = data;
        // geometry change restarts the frame and drops any tail
        col_pos  = 0;
        row_pos  = 0;
        out_idx  = 0;
        tail_due = 1'b0;
      end
      REG_STRENGTH: gain_reg = data[GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  // the pixel arriving now is not in the row store yet
  function automatic rgb_t tap_at(int unsigned rr, int unsigned cc, bit have_new, rgb_t px);
    if (have_new && rr == row_pos && cc == col_pos) return px;
    return row_store[(rr % ROW_SLOTS) * DEF_MAX_WIDTH + cc];
  endfunction

  function automatic logic [PIX_W-1:0] boost_chan(int unsigned sh);
    int p, acc, g, num, k;
    p   = (win_taps[4] >> sh) & 24'hFF;
    acc = 0;
    for (k = 0; k < 9; k++) acc += (win_taps[k] >> sh) & 24'hFF;
    g   = (gain_reg > GAIN_MAX) ? GAIN_MAX : gain_reg;
    num = p * BOOST_SCALE + g * (9 * p - acc);
    if (num < 0) return '0;
    num = num / BOOST_SCALE;
    return (num > 255) ? PIX_MAX : 8'(num);
  endfunction

  // builds the window of pixel out_idx with replicated borders, then steps on
  function automatic sharp_res_t window_result(bit have_new, rgb_t px);
    int unsigned w, h, r, c, rr, cc, dr, dc;
    sharp_res_t res;
    w = frame_w();
    h = frame_h();
    r = out_idx / w;
    c = out_idx % w;
    for (dr = 0; dr < 3; dr++) begin
      rr = (r == 0 && dr == 0) ? 0 : r + dr - 1;
      if (rr > h - 1) rr = h - 1;
      for (dc = 0; dc < 3; dc++) begin
        cc = (c == 0 && dc == 0) ? 0 : c + dc - 1;
        if (cc > w - 1) cc = w - 1;
        win_taps[dr*3 + dc] = tap_at(rr, cc, have_new, px);
      end
    end
    res.px.r = boost_chan(16);
    res.px.g = boost_chan(8);
    res.px.b = boost_chan(0);
    res.eof  = (out_idx + 1 == w * h);
    out_idx++;
    if (out_idx >= w * h) begin
      out_idx  = 0;
      tail_due = 1'b0;
    end
    return res;
  endfunction

  // one accepted item; returns 1 when it releases a result
  function automatic bit sharpen_advance(rgb_t px, bit fl, output sharp_res_t res);
    int unsigned w, h;
    bit fire;
    res = '0;
    // a pixel during drain counts as a flush
    if (fl || tail_due) begin
      if (!tail_due) return 1'b0;
      res = window_result(1'b0, px);
      return 1'b1;
    end
    w    = frame_w();
    h    = frame_h();
    fire = (row_pos * w + col_pos) >= w + 1;
    if (fire) res = window_result(1'b1, px);
    row_store[(row_pos % ROW_SLOTS) * DEF_MAX_WIDTH + col_pos] = px;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) begin
        row_pos  = 0;
        tail_due = 1'b1;
      end
    end
    return fire;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  // extremes are common so the clamps get hit
  function automatic logic [PIX_W-1:0] rand_chan();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return PIX_MAX;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic rgb_t rand_px();
    rgb_t v;
    v.r = rand_chan();
    v.g = rand_chan();
    v.b = rand_chan();
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CFG_DATA_W'(GAIN_MAX);
      2: return 12'h1FF;
      3: return 12'($urandom_range(257, 4095));   // upper bits masked off
      default: return 12'($urandom_range(0, 256));
    endcase
  endfunction

  // mostly small frames; some below the minimum
  function automatic logic [CFG_DATA_W-1:0] pick_dim(int unsigned top);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 13) return 12'($urandom_range(MIN_DIM, top));
    if (r < 16) return 12'($urandom_range(top + 1, 4 * top));
    if (r < 18) return 12'($urandom_range(0, 1));
    return 12'($urandom_range(MIN_DIM, top));
  endfunction

  // Register write: only once the core has gone quiet. Warm-up pixels leave no
  // result behind, so a few extra clocks let them clear the pipeline.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    pix_if.valid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sharpen_cfg(idx, data);
  endtask

  // Drives one item and waits for it to be taken. Called in the step of the
  // previous acceptance, so valid stays high when no gap is drawn.
  task automatic send_item(rgb_t px, bit fl, row_kind_e kind, sharp_res_t given);
    int unsigned gap;
    sharp_res_t  pred;
    bit          fire;
    gap = draw_gap(send_calm);
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid    <= 1'b1;
    pix_if.red_in   <= px.r;
    pix_if.green_in <= px.g;
    pix_if.blue_in  <= px.b;
    pix_if.flush    <= fl;
    do @(posedge clk_i); while (!pix_if.ready);
    fire = sharpen_advance(px, fl, pred);
    if (kind == ROW_GIVEN) due_pixels.push_back(given);
    else if (kind == ROW_PRED && fire) due_pixels.push_back(pred);
  endtask

  // Well-formed stream: pixels in raster order, the tail drained by flushes
  // or dropped pixels, a few stray flushes mid-frame. Stray flushes are
  // ignored by the core and do not count toward the quota.
  task automatic run_phase(int unsigned quota);
    int unsigned taken;
    bit          fl;
    rgb_t        px;
    taken = 0;
    while (taken < quota) begin
      px = rand_px();
      if (tail_due) fl = ($urandom_range(0, 9) != 0);
      else fl = ($urandom_range(0, 19) == 0);
      if (!fl || tail_due) taken++;
      send_item(px, fl, ROW_PRED, '0);
    end
  endtask

  task automatic note_fail(string what, sharp_res_t want, sharp_res_t got);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("%0t: %s: expected rgb %h eof %b, got rgb %h eof %b",
               $time, what, want.px, want.eof, got.px, got.eof);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, result side, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : result_sink
    int unsigned gap;
    sharp_res_t  got;
    sharp_res_t  want;
    res_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      gap = draw_gap(recv_calm);
      if (gap != 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      got.px  = {res_if.red_out, res_if.green_out, res_if.blue_out};
      got.eof = res_if.end_of_frame;
      if (due_pixels.size() == 0) begin
        note_fail("result with none expected", '0, got);
      end else begin
        want = due_pixels.pop_front();
        if (got !== want) note_fail("result mismatch", want, got);
      end
    end
  end

  // ends the run when neither channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t    row;
    int unsigned random_done;
    int unsigned phase_no;
    int unsigned n;

    rst_ni          <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= '0;
    cfg_data        <= '0;
    pix_if.valid    <= 1'b0;
    pix_if.red_in   <= '0;
    pix_if.green_in <= '0;
    pix_if.blue_in  <= '0;
    pix_if.flush    <= 1'b0;
    send_calm   = 1'b0;
    recv_calm   = 1'b0;
    sharpen_reset();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) write_reg(row.idx, row.data);
      else send_item(row.px, row.fl, row.kind, '{row.exp_px, row.exp_eof});
    end

    // Random phases. Each one sets a new gain, often new geometry (dropping
    // whatever frame or tail was in progress), sometimes neither so the gain
    // changes mid-frame. Two phases start a frame with one side at its largest
    // size and abandon it part way.
    random_done = 0;
    phase_no    = 0;
    while (random_done < RANDOM_ITEMS) begin
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      write_reg(REG_STRENGTH, pick_gain());
      if (phase_no == 2) begin
        write_reg(REG_FRAME_WIDTH, $urandom_range(0, 1) ? 12'd2048 : 12'hFFF);
        write_reg(REG_FRAME_HEIGHT, 12'($urandom_range(0, 2)));
        n = 100;
      end else if (phase_no == 5) begin
        write_reg(REG_FRAME_WIDTH, 12'($urandom_range(0, 2)));
        write_reg(REG_FRAME_HEIGHT, $urandom_range(0, 1) ? 12'd2048 : 12'hFFF);
        n = 150;
      end else begin
        if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, 12'($urandom));
        case ($urandom_range(0, 3))
          0: write_reg(REG_FRAME_WIDTH, pick_dim(10));
          1: write_reg(REG_FRAME_HEIGHT, pick_dim(6));
          2: begin
            write_reg(REG_FRAME_WIDTH, pick_dim(10));
            write_reg(REG_FRAME_HEIGHT, pick_dim(6));
          end
          default: ;
        endcase
        n = $urandom_range(10, 120);
      end
      run_phase(n);
      random_done += n;
      phase_no++;
    end

    // drain, then give a late extra result time to show up
    pix_if.valid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk_i);
    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* rgb_sharpen_3x3_core.f */
rtl/core/rsh3_pkg.sv
rtl/core/rsh3_if.sv
rtl/core/rsh3_line_store.sv
rtl/core/rsh3_window.sv
rtl/core/rsh3_chan.sv
rtl/core/rgb_sharpen_3x3_core.sv
tb/rgb_sharpen_3x3_core_tb.sv
